### src/rotation_matrix_to_quaternion_top_macros.svh
// assertion macros for the checker file of the quaternion converter
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH

// property checked only out of reset
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define RMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/rmq_pkg.sv
// shared types and constants of the rotation matrix to quaternion converter
// no dependencies
package rmq_pkg;

  // width of one matrix entry and one quaternion component
  localparam int FIELD_W = 32;
  // block-scaled magnitudes have their leading one at this bit
  localparam int NORM_POS = 30;
  localparam int MAG_W = NORM_POS + 1;
  // integer root width and squared-sum width
  localparam int ROOT_W = 32;
  localparam int SUM_W = 2 * ROOT_W;

  typedef enum logic [1:0] {
    BR_TRACE  = 2'd0,
    BR_FIRST  = 2'd1,
    BR_SECOND = 2'd2,
    BR_THIRD  = 2'd3
  } branch_t;

  typedef logic [MAG_W-1:0] mag_t;

  // item payload once the vector is block-scaled
  typedef struct packed {
    mag_t [3:0] mag;
    logic [3:0] neg;
    branch_t    branch;
    logic       invalid;
  } pl_t;

endpackage

### src/rotation_matrix_to_quaternion_top.sv
// rotation matrix to unit quaternion converter, fully pipelined
// depends on rmq_pkg
//
// Usage: one 3x3 rotation matrix in signed fixed point (FRAC_BITS fraction
// bits) enters per transfer on the in_ stream; one unit quaternion leaves per
// transfer on the out_ stream, with the chosen path and an invalid flag in
// out_tuser. A non-positive root argument gives a zero quaternion with the
// invalid flag set.
// Pipeline: includes the 32-stage integer square root and the FRAC_BITS-stage
// restoring divider, one quotient bit per stage in each of four lanes.
// Throughput: one matrix per cycle, back to back, while the output is not stalled.
// Stalls: all stages move together while the output register is empty or
// being taken. A one-entry holding register at the input keeps in_tready
// registered, so one more transfer is taken while a result waits.
// Reset: rst_n clears all valid bits and the holding register; the block
// takes a transfer as soon as reset is released.
module rotation_matrix_to_quaternion_top
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 30
) (
  input  logic         clk,
  input  logic         rst_n,
  // e00, e01, e02, e10, e11, e12, e20, e21, e22, 32 bits each
  input  logic [287:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // qw, qx, qy, qz, 32 bits each
  output logic [127:0] out_tdata,
  // branch [1:0], invalid [2]
  output logic [2:0]   out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready
);

  localparam int VW = (FRAC_BITS + 3 > 35) ? FRAC_BITS + 3 : 35;
  localparam int NCH = (VW + 7) / 8;
  localparam int PADW = NCH * 8;
  localparam int PW = $clog2(PADW);
  localparam int CW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic signed [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;
  localparam int NSQ = ROOT_W;

  logic adv;
  logic out_v_r;

  assign adv = !out_v_r || out_tready;

  // input holding register
  logic         hold_v_r;
  logic [287:0] hold_d_r;
  logic         in_xfer;
  logic         src_v;
  logic [287:0] src_d;

  assign in_tready = !hold_v_r;
  assign in_xfer = in_tvalid && !hold_v_r;
  assign src_v = hold_v_r || in_xfer;
  assign src_d = hold_v_r ? hold_d_r : in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (adv) begin
      hold_v_r <= 1'b0;
    end else if (in_xfer) begin
      hold_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_xfer) begin
      hold_d_r <= in_tdata;
    end
  end

  // stage 1: register the entries
  logic                      s1_v_r;
  logic signed [FIELD_W-1:0] s1_e_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= src_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        s1_e_r[i] <= src_d[i*FIELD_W +: FIELD_W];
      end
    end
  end

  // stage 2: root arguments, pair sums and differences, diagonal compares
  logic                 s2_v_r;
  logic signed [VW-1:0] s2_rt_r, s2_r1_r, s2_r2_r, s2_r3_r;
  logic signed [VW-1:0] s2_d12_r, s2_d20_r, s2_d01_r, s2_s10_r, s2_s02_r, s2_s21_r;
  logic                 s2_g0_r, s2_g1_r;
  logic signed [VW-1:0] a [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      a[i] = VW'(s1_e_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_rt_r  <= a[0] + a[4] + a[8] + ONE_V;
      s2_r1_r  <= ONE_V + a[0] - a[4] - a[8];
      s2_r2_r  <= ONE_V + a[4] - a[0] - a[8];
      s2_r3_r  <= ONE_V + a[8] - a[0] - a[4];
      s2_d12_r <= a[5] - a[7];
      s2_d20_r <= a[6] - a[2];
      s2_d01_r <= a[1] - a[3];
      s2_s10_r <= a[3] + a[1];
      s2_s02_r <= a[2] + a[6];
      s2_s21_r <= a[7] + a[5];
      s2_g0_r  <= (s1_e_r[0] > s1_e_r[4]) && (s1_e_r[0] > s1_e_r[8]);
      s2_g1_r  <= s1_e_r[4] > s1_e_r[8];
    end
  end

  // stage 3: path select, vector assembly, magnitudes and signs
  logic                 s3_v_r;
  logic [VW-1:0]        s3_mag_r [4];
  logic [3:0]           s3_neg_r;
  branch_t              s3_br_r;
  logic                 s3_inv_r;
  branch_t              br_sel;
  logic signed [VW-1:0] vsel [4];
  logic signed [VW-1:0] root_sel;

  always_comb begin
    if (s2_rt_r > 0) begin
      br_sel = BR_TRACE;
    end else if (s2_g0_r) begin
      br_sel = BR_FIRST;
    end else if (s2_g1_r) begin
      br_sel = BR_SECOND;
    end else begin
      br_sel = BR_THIRD;
    end
    unique case (br_sel)
      BR_TRACE: begin
        root_sel = s2_rt_r;
        vsel[0] = s2_rt_r;  vsel[1] = s2_d12_r; vsel[2] = s2_d20_r; vsel[3] = s2_d01_r;
      end
      BR_FIRST: begin
        root_sel = s2_r1_r;
        vsel[0] = s2_d12_r; vsel[1] = s2_r1_r;  vsel[2] = s2_s10_r; vsel[3] = s2_s02_r;
      end
      BR_SECOND: begin
        root_sel = s2_r2_r;
        vsel[0] = s2_d20_r; vsel[1] = s2_s10_r; vsel[2] = s2_r2_r;  vsel[3] = s2_s21_r;
      end
      default: begin
        root_sel = s2_r3_r;
        vsel[0] = s2_d01_r; vsel[1] = s2_s02_r; vsel[2] = s2_s21_r; vsel[3] = s2_r3_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_br_r  <= br_sel;
      s3_inv_r <= root_sel <= 0;
      for (int i = 0; i < 4; i++) begin
        s3_neg_r[i] <= vsel[i][VW-1];
        s3_mag_r[i] <= vsel[i][VW-1] ? VW'(-vsel[i]) : VW'(vsel[i]);
      end
    end
  end

  // stage 4: or of magnitudes and per-byte nonzero flags
  logic            s4_v_r;
  logic [PADW-1:0] s4_or_r;
  logic [NCH-1:0]  s4_chf_r;
  logic [VW-1:0]   s4_mag_r [4];
  logic [3:0]      s4_neg_r;
  branch_t         s4_br_r;
  logic            s4_inv_r;
  logic [PADW-1:0] or_w;

  always_comb begin
    or_w = PADW'(s3_mag_r[0] | s3_mag_r[1] | s3_mag_r[2] | s3_mag_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_or_r  <= or_w;
      for (int c = 0; c < NCH; c++) begin
        s4_chf_r[c] <= |or_w[c*8 +: 8];
      end
      s4_mag_r <= s3_mag_r;
      s4_neg_r <= s3_neg_r;
      s4_br_r  <= s3_br_r;
      s4_inv_r <= s3_inv_r;
    end
  end

  // stage 5: leading-one position of the largest magnitude
  logic          s5_v_r;
  logic [PW-1:0] s5_pos_r;
  logic [VW-1:0] s5_mag_r [4];
  logic [3:0]    s5_neg_r;
  branch_t       s5_br_r;
  logic          s5_inv_r;
  logic [CW-1:0] csel;
  logic [7:0]    cbyte;
  logic [2:0]    bsel;
  logic [PW-1:0] pos_w;

  always_comb begin
    csel = '0;
    for (int c = 0; c < NCH; c++) begin
      if (s4_chf_r[c]) begin
        csel = CW'(c);
      end
    end
    cbyte = s4_or_r[csel*8 +: 8];
    bsel = '0;
    for (int b = 0; b < 8; b++) begin
      if (cbyte[b]) begin
        bsel = 3'(b);
      end
    end
    pos_w = PW'({csel, bsel});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_pos_r <= pos_w;
      s5_mag_r <= s4_mag_r;
      s5_neg_r <= s4_neg_r;
      s5_br_r  <= s4_br_r;
      s5_inv_r <= s4_inv_r || !(|s4_chf_r);
    end
  end

  // stage 6: block scaling to put the leading one at NORM_POS
  logic          s6_v_r;
  pl_t           s6_pl_r;
  logic [PW-1:0] sh_r, sh_l;
  logic          sh_right;
  pl_t           pl6;

  always_comb begin
    sh_right = s5_pos_r >= PW'(NORM_POS);
    sh_r = s5_pos_r - PW'(NORM_POS);
    sh_l = PW'(NORM_POS) - s5_pos_r;
    for (int i = 0; i < 4; i++) begin
      if (sh_right) begin
        pl6.mag[i] = MAG_W'(s5_mag_r[i] >> sh_r);
      end else begin
        pl6.mag[i] = MAG_W'(s5_mag_r[i] << sh_l);
      end
    end
    pl6.neg = s5_neg_r;
    pl6.branch = s5_br_r;
    pl6.invalid = s5_inv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_pl_r <= pl6;
    end
  end

  // stage 7: four squares
  logic                   s7_v_r;
  pl_t                    s7_pl_r;
  logic [2*MAG_W-1:0]     s7_sq_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (adv) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_pl_r <= s6_pl_r;
      for (int i = 0; i < 4; i++) begin
        s7_sq_r[i] <= (2*MAG_W)'(s6_pl_r.mag[i]) * (2*MAG_W)'(s6_pl_r.mag[i]);
      end
    end
  end

  // stage 8: pairwise sums
  logic             s8_v_r;
  pl_t              s8_pl_r;
  logic [2*MAG_W:0] s8_p0_r, s8_p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (adv) begin
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_pl_r <= s7_pl_r;
      s8_p0_r <= (2*MAG_W+1)'(s7_sq_r[0]) + (2*MAG_W+1)'(s7_sq_r[1]);
      s8_p1_r <= (2*MAG_W+1)'(s7_sq_r[2]) + (2*MAG_W+1)'(s7_sq_r[3]);
    end
  end

  // square root pipeline: entry 0 holds the sum, one root bit per stage
  logic                sq_v_r   [NSQ+1];
  pl_t                 sq_pl_r  [NSQ+1];
  logic [SUM_W-1:0]    sq_s_r   [NSQ+1];
  logic [ROOT_W+1:0]   sq_rem_r [NSQ+1];
  logic [ROOT_W-1:0]   sq_res_r [NSQ+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_pl_r[0]  <= s8_pl_r;
      sq_s_r[0]   <= SUM_W'(s8_p0_r) + SUM_W'(s8_p1_r);
      sq_rem_r[0] <= '0;
      sq_res_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [ROOT_W+3:0] cur;
    logic [ROOT_W+3:0] trial;
    logic              take;

    // bring down two bits and try a one in the next root bit
    always_comb begin
      cur = {sq_rem_r[k], sq_s_r[k][SUM_W-1 -: 2]};
      trial = {2'b00, sq_res_r[k], 2'b01};
      take = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_pl_r[k+1]  <= sq_pl_r[k];
        sq_s_r[k+1]   <= {sq_s_r[k][SUM_W-3:0], 2'b00};
        sq_rem_r[k+1] <= take ? (ROOT_W+2)'(cur - trial) : (ROOT_W+2)'(cur);
        sq_res_r[k+1] <= {sq_res_r[k][ROOT_W-2:0], take};
      end
    end
  end

  // divider pipeline: entry 0 holds the integer quotient bit, then one
  // fraction bit per stage in each lane
  logic                          dv_v_r   [FRAC_BITS+1];
  logic [3:0]                    dv_neg_r [FRAC_BITS+1];
  branch_t                       dv_br_r  [FRAC_BITS+1];
  logic                          dv_inv_r [FRAC_BITS+1];
  logic [ROOT_W-1:0]             dv_n_r   [FRAC_BITS+1];
  logic [3:0][ROOT_W-1:0]        dv_rem_r [FRAC_BITS+1];
  logic [3:0][ROOT_W:0]          dv_q_r   [FRAC_BITS+1];
  logic [ROOT_W-1:0]             n_w;
  pl_t                           pl_n;

  assign n_w = sq_res_r[NSQ];
  assign pl_n = sq_pl_r[NSQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_neg_r[0] <= pl_n.neg;
      dv_br_r[0]  <= pl_n.branch;
      dv_inv_r[0] <= pl_n.invalid || (n_w == '0);
      dv_n_r[0]   <= n_w;
      for (int i = 0; i < 4; i++) begin
        if (ROOT_W'(pl_n.mag[i]) >= n_w) begin
          dv_q_r[0][i]   <= (ROOT_W+1)'(1);
          dv_rem_r[0][i] <= ROOT_W'(pl_n.mag[i]) - n_w;
        end else begin
          dv_q_r[0][i]   <= '0;
          dv_rem_r[0][i] <= ROOT_W'(pl_n.mag[i]);
        end
      end
    end
  end

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    logic [3:0][ROOT_W:0] cur;
    logic [3:0]           ge;

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        cur[i] = {dv_rem_r[k][i], 1'b0};
        ge[i] = cur[i] >= {1'b0, dv_n_r[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_neg_r[k+1] <= dv_neg_r[k];
        dv_br_r[k+1]  <= dv_br_r[k];
        dv_inv_r[k+1] <= dv_inv_r[k];
        dv_n_r[k+1]   <= dv_n_r[k];
        for (int i = 0; i < 4; i++) begin
          dv_rem_r[k+1][i] <= ge[i] ? ROOT_W'(cur[i] - {1'b0, dv_n_r[k]}) : ROOT_W'(cur[i]);
          // a quotient that reaches 2^32 is frozen, it saturates at the output
          dv_q_r[k+1][i] <= dv_q_r[k][i][ROOT_W] ? dv_q_r[k][i]
                                                 : {dv_q_r[k][i][ROOT_W-1:0], ge[i]};
        end
      end
    end
  end

  // output register: sign, saturation, invalid zeroing
  logic [127:0] out_d_r;
  logic [2:0]   out_u_r;
  logic [127:0] q_out;
  logic [ROOT_W:0] qf;

  always_comb begin
    q_out = '0;
    for (int i = 0; i < 4; i++) begin
      qf = dv_q_r[FRAC_BITS][i];
      if (dv_inv_r[FRAC_BITS]) begin
        q_out[i*FIELD_W +: FIELD_W] = '0;
      end else if (dv_neg_r[FRAC_BITS][i]) begin
        if (qf > (ROOT_W+1)'(33'h0_8000_0000)) begin
          q_out[i*FIELD_W +: FIELD_W] = 32'h8000_0000;
        end else begin
          q_out[i*FIELD_W +: FIELD_W] = FIELD_W'(-qf);
        end
      end else begin
        if (qf > (ROOT_W+1)'(33'h0_7FFF_FFFF)) begin
          q_out[i*FIELD_W +: FIELD_W] = 32'h7FFF_FFFF;
        end else begin
          q_out[i*FIELD_W +: FIELD_W] = FIELD_W'(qf);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v_r[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d_r <= q_out;
      out_u_r <= {dv_inv_r[FRAC_BITS], dv_br_r[FRAC_BITS]};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;
  assign out_tuser = out_u_r;

endmodule

### src/rmq_checker.sv
// port-level checks of the quaternion converter, bound to its top level
// depends on rmq_pkg and rotation_matrix_to_quaternion_top_macros.svh
`include "rotation_matrix_to_quaternion_top_macros.svh"

module rmq_checker
  import rmq_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [127:0] out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tvalid,
  input logic         out_tready
);

  // nothing leaves straight after reset
  `RMQ_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_tvalid, "output valid after reset")

  // a stalled result stays offered
  `RMQ_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // an invalid result carries a zero quaternion
  `RMQ_ASSERT(a_inv_zero, out_tvalid && out_tuser[2] |-> out_tdata == 128'd0, "invalid result not zero")

  // on the trace path the scalar part is never negative
  `RMQ_ASSERT(a_trace_w, out_tvalid && out_tuser[1:0] == BR_TRACE && !out_tuser[2] |-> !out_tdata[31], "negative scalar on trace path")

  // the input is only held off while a result waits
  `RMQ_ASSERT(a_in_block, in_tvalid && !in_tready |-> out_tvalid, "input blocked with no result waiting")

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

### tb/sv/tb.sv
// testbench for the rotation matrix to quaternion converter
// depends on rmq_pkg and rotation_matrix_to_quaternion_top; checks every result
// against a behavioural model of the shepperd conversion
module tb;
  import rmq_pkg::*;

  localparam int FRAC = 30;
  localparam logic signed [31:0] ONE_Q = 32'sd1 << FRAC;

  typedef logic signed [31:0] ent_t;

  typedef struct packed {
    logic signed [31:0] qz;
    logic signed [31:0] qy;
    logic signed [31:0] qx;
    logic signed [31:0] qw;
    branch_t            branch;
    logic               invalid;
  } quat_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [287:0] in_tdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;

  quat_t expected_quats[$];
  int    mismatches = 0;
  int    stall_pct = 9;
  bit    timed_out = 1'b0;

  rotation_matrix_to_quaternion_top #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // integer square root, floor
  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // floor(mag * 2^FRAC / n), capped at 2^32
  function automatic logic [63:0] frac_quot(logic [63:0] mag, logic [63:0] n);
    logic [63:0] q;
    logic [63:0] rem;
    q = mag / n;
    rem = mag % n;
    if (q > (64'd1 << 32)) q = 64'd1 << 32;
    for (int i = 0; i < FRAC; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= n) begin
        rem -= n;
        q |= 64'd1;
      end
      if (q > (64'd1 << 32)) q = 64'd1 << 32;
    end
    return q;
  endfunction

  // shepperd conversion with block scaling and normalisation
  function automatic quat_t to_quat(logic [287:0] d);
    longint m[9];
    longint v[4];
    longint root;
    logic [63:0] mag[4];
    logic [63:0] maxm;
    logic [63:0] sum;
    logic [63:0] n;
    logic [63:0] q;
    logic [31:0] comp[4];
    quat_t r;
    for (int i = 0; i < 9; i++) m[i] = longint'(ent_t'(d[32*i +: 32]));
    r = '0;
    root = m[0] + m[4] + m[8] + longint'(ONE_Q);
    if (root > 0) begin
      r.branch = BR_TRACE;
      v[0] = root; v[1] = m[5] - m[7]; v[2] = m[6] - m[2]; v[3] = m[1] - m[3];
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      r.branch = BR_FIRST;
      root = longint'(ONE_Q) + m[0] - m[4] - m[8];
      v[0] = m[5] - m[7]; v[1] = root; v[2] = m[3] + m[1]; v[3] = m[2] + m[6];
    end else if (m[4] > m[8]) begin
      r.branch = BR_SECOND;
      root = longint'(ONE_Q) + m[4] - m[0] - m[8];
      v[0] = m[6] - m[2]; v[1] = m[3] + m[1]; v[2] = root; v[3] = m[7] + m[5];
    end else begin
      r.branch = BR_THIRD;
      root = longint'(ONE_Q) + m[8] - m[0] - m[4];
      v[0] = m[1] - m[3]; v[1] = m[6] + m[2]; v[2] = m[7] + m[5]; v[3] = root;
    end
    if (root <= 0) begin
      r.invalid = 1'b1;
      return r;
    end
    maxm = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
      if (mag[i] > maxm) maxm = mag[i];
    end
    if (maxm == 0) begin
      r.invalid = 1'b1;
      return r;
    end
    while (maxm >= (64'd1 << 31)) begin
      maxm >>= 1;
      for (int i = 0; i < 4; i++) mag[i] >>= 1;
    end
    while (maxm < (64'd1 << 30)) begin
      maxm <<= 1;
      for (int i = 0; i < 4; i++) mag[i] <<= 1;
    end
    sum = '0;
    for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
    n = int_sqrt(sum);
    if (n == 0) begin
      r.invalid = 1'b1;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      q = frac_quot(mag[i], n);
      if (v[i] < 0) begin
        if (q > (64'd1 << 31)) q = 64'd1 << 31;
        comp[i] = 32'(-q);
      end else begin
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        comp[i] = q[31:0];
      end
    end
    r.qw = comp[0]; r.qx = comp[1]; r.qy = comp[2]; r.qz = comp[3];
    return r;
  endfunction

  // one matrix transfer, with random idle cycles ahead of it
  task automatic send_matrix(logic [287:0] d);
    while ($urandom_range(99) < stall_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_quats.push_back(to_quat(d));
  endtask

  // input side goes idle after the last transfer
  task automatic stop_sending();
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [287:0] pack_mat(ent_t a0, ent_t a1, ent_t a2, ent_t a3,
      ent_t a4, ent_t a5, ent_t a6, ent_t a7, ent_t a8);
    return {a8, a7, a6, a5, a4, a3, a2, a1, a0};
  endfunction

  function automatic ent_t rnd_ent();
    case ($urandom_range(5))
      0: return ent_t'($urandom);
      1: return 32'sh8000_0000;
      2: return 32'sh7FFF_FFFF;
      default: return ent_t'($urandom_range(2 * ONE_Q)) - ONE_Q;
    endcase
  endfunction

  // rotation-like matrix with a chosen sign pattern on the diagonal
  function automatic logic [287:0] rnd_rotation(int path);
    ent_t e[9];
    for (int i = 0; i < 9; i++) e[i] = ent_t'($urandom_range(2 * ONE_Q)) - ONE_Q;
    if (path != 0) begin
      for (int i = 0; i < 9; i += 4) e[i] = -ent_t'($urandom_range(ONE_Q / 2));
      e[4 * (path - 1)] = ent_t'($urandom_range(ONE_Q / 4));
    end
    return pack_mat(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
  endfunction

  task automatic test_paths();
    send_matrix(pack_mat(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
    send_matrix(pack_mat(ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
    send_matrix(pack_mat(-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q));
    send_matrix(pack_mat(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q));
    send_matrix(pack_mat(0, -ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q));
    // ties on the diagonal go to the later entry
    send_matrix(pack_mat(-ONE_Q / 2, 5, 7, -3, -ONE_Q / 2, 9, 1, 2, -ONE_Q / 2));
    send_matrix(pack_mat(0, 1, 2, 3, 0, 4, 5, 6, -ONE_Q));
  endtask

  task automatic test_invalid();
    // matrices with negative or extreme diagonal entries
    send_matrix(pack_mat(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
    send_matrix(pack_mat(32'sh8000_0000, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0,
                         32'sh7FFF_FFFF));
    send_matrix(pack_mat(-ONE_Q, 3, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q + 1));
    send_matrix(pack_mat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                         32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                         32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
  endtask

  task automatic test_extremes();
    send_matrix({9{32'h7FFF_FFFF}});
    send_matrix('1);
    send_matrix('0);
    send_matrix(pack_mat(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                         32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_matrix(pack_mat(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                         1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1));
    send_matrix({9{32'h5555_5555}});
    send_matrix({9{32'hAAAA_AAAA}});
  endtask

  // holds off until the pipeline has drained
  task automatic test_drain_pause();
    for (int i = 0; i < 5; i++) send_matrix(rnd_rotation(i % 4));
    stop_sending();
    while (expected_quats.size() != 0) @(posedge clk);
    for (int i = 0; i < 5; i++) send_matrix(rnd_rotation($urandom_range(3)));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0)
        send_matrix(pack_mat(rnd_ent(), rnd_ent(), rnd_ent(), rnd_ent(), rnd_ent(),
                             rnd_ent(), rnd_ent(), rnd_ent(), rnd_ent()));
      else
        send_matrix(rnd_rotation($urandom_range(3)));
    end
  endtask

  // result side: random back-pressure
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    quat_t got;
    quat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser[1:0], out_tuser[2]};
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_quats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected w=%h x=%h y=%h z=%h br=%0d inv=%b, got w=%h x=%h y=%h z=%h br=%0d inv=%b",
                     want.qw, want.qx, want.qy, want.qz, want.branch, want.invalid,
                     got.qw, got.qx, got.qy, got.qz, got.branch, got.invalid);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_paths();
    test_invalid();
    test_extremes();
    test_drain_pause();
    // stretch with no idling on either side
    stall_pct = 0;
    test_random(150);
    stall_pct = 9;
    test_random(370);
    stop_sending();
    while (expected_quats.size() != 0 && !timed_out) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_quats.size() == 0 && !timed_out)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    timed_out = 1'b1;
    $display("tb NOT OK");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/rmq_pkg.sv
src/rotation_matrix_to_quaternion_top.sv
src/rmq_checker.sv
tb/sv/tb.sv
